FILE: rtl/core/mfq_pkg.sv
// mfq_pkg: shared types, codes and helpers of the multilevel feedback queue scheduler
// no dependencies; imported by every module of the block
package mfq_pkg;

    localparam int MFQ_MAX_LEVELS  = 8;
    localparam int MFQ_MAX_TASKS   = 64;
    localparam int MFQ_LEVEL_DEPTH = 64;

    localparam int OP_W       = 3;
    localparam int TASK_W     = 6;
    localparam int PRIO_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int OUT_LVL_W  = 3;
    localparam int SLICE_W    = 17;
    localparam int LC_W       = 4;
    localparam int BQ_W       = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // widest level index and task index the parameters allow
    localparam int LVL_MAX_W  = 4;
    localparam int TIDX_MAX_W = 10;
    // width of the number of levels in use (up to 16)
    localparam int NLV_W      = 5;

    localparam logic [OP_W-1:0] OP_ARRIVAL  = 3'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
    localparam logic [OP_W-1:0] OP_IO_DONE  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXPIRE   = 3'd3;
    localparam logic [OP_W-1:0] OP_PICK     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_QUANTUM = 1'b1;

    localparam logic [LC_W-1:0] LC_RESET = 4'd3;
    localparam logic [BQ_W-1:0] BQ_RESET = 10'd5;

    localparam logic [3:0] PRIO_TOP = 4'd10;
    localparam logic [8:0] PRIO_DIV = 9'd11;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [LVL_MAX_W-1:0] level;
        logic [TASK_W-1:0]    data;
    } t_fifo_cmd;

    typedef struct packed {
        logic                  we;
        logic                  valid;
        logic [LVL_MAX_W-1:0]  level;
        logic [TIDX_MAX_W-1:0] addr;
    } t_map_wr;

    // floor(clamp(prio,0,10) * n / 11), zero for a single level
    function automatic logic [LVL_MAX_W-1:0] prio_level(
        input logic signed [PRIO_W-1:0] prio,
        input logic [NLV_W-1:0]         n
    );
        logic [3:0] p;
        logic [8:0] rem;
        logic [3:0] q;
        p = 4'd0;
        q = 4'd0;
        if (prio > 8'sd10) begin
            p = PRIO_TOP;
        end else if (prio > 8'sd0) begin
            p = prio[3:0];
        end
        rem = 9'(p) * 9'(n);
        for (int k = 3; k >= 0; k--) begin
            if (rem >= (PRIO_DIV << k)) begin
                rem  = rem - (PRIO_DIV << k);
                q[k] = 1'b1;
            end
        end
        if (n <= 5'd1) begin
            q = 4'd0;
        end
        return q;
    endfunction

endpackage

FILE: rtl/core/mfq_level_store.sv
// mfq_level_store: per-level ring buffers in one synchronous memory, with head,
// tail and occupancy registers per level; depends on mfq_pkg
module mfq_level_store import mfq_pkg::*; #(
    parameter int MAX_LEVELS  = MFQ_MAX_LEVELS,
    parameter int LEVEL_DEPTH = MFQ_LEVEL_DEPTH,
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [LW-1:0]         i_rd_level,
    input  t_fifo_cmd             i_cmd,
    output logic [TASK_W-1:0]     o_rd_data,
    output logic [MAX_LEVELS-1:0] o_nonempty,
    output logic [MAX_LEVELS-1:0] o_full
);

    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH = MAX_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [PW-1:0]     r_head  [MAX_LEVELS];
    logic [PW-1:0]     r_tail  [MAX_LEVELS];
    logic [CW-1:0]     r_count [MAX_LEVELS];
    logic [PW-1:0]     r_next_head;
    logic [TASK_W-1:0] r_mem   [DEPTH];
    logic [TASK_W-1:0] r_rd_data;

    logic [LW-1:0] lvl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
        return (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign lvl     = i_cmd.level[LW-1:0];
    assign wr_addr = AW'(lvl) * AW'(LEVEL_DEPTH) + AW'(r_tail[lvl]);
    assign rd_addr = AW'(i_rd_level) * AW'(LEVEL_DEPTH) + AW'(r_head[i_rd_level]);

    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            o_nonempty[i] = (r_count[i] != '0);
            o_full[i]     = (r_count[i] == CW'(LEVEL_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_cmd.push) begin
            r_tail[lvl]  <= next_ptr(r_tail[lvl]);
            r_count[lvl] <= r_count[lvl] + 1'b1;
        end else if (i_cmd.pop) begin
            r_head[lvl]  <= r_next_head;
            r_count[lvl] <= r_count[lvl] - 1'b1;
        end
    end

    // head successor captured with the read, used by the pop that follows
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_next_head <= next_ptr(r_head[i_rd_level]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mfq_task_map.sv
// mfq_task_map: recorded level of each task in one synchronous memory,
// cleared by a sweep after reset; depends on mfq_pkg
module mfq_task_map import mfq_pkg::*; #(
    parameter int MAX_TASKS  = MFQ_MAX_TASKS,
    parameter int MAX_LEVELS = MFQ_MAX_LEVELS,
    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
    localparam int TIW = $clog2(MAX_TASKS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic [TIW-1:0] i_rd_addr,
    input  t_map_wr        i_wr,
    output logic [LW:0]    o_rd_data,
    output logic           o_clearing
);

    logic [LW:0]    r_mem [MAX_TASKS];
    logic [LW:0]    r_rd_data;
    logic           r_clearing;
    logic [TIW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == TIW'(MAX_TASKS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.we) begin
            r_mem[i_wr.addr[TIW-1:0]] <= {i_wr.valid, i_wr.level[LW-1:0]};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

FILE: rtl/core/multilevel_feedback_queue_scheduler.sv
// multilevel feedback queue scheduler: one result per command, strobed after the command
// transfer through the EXEC state and the result registers; busy holds off a new command
// during EXEC (read of the level and map memories, then the read-modify-write of both)
// synchronous active-low reset; afterwards busy stays high while the task map (MAX_TASKS
// entries, 64 by default) is swept clear; configuration is taken meanwhile
// the receiver cannot stall: o_done strobes each result for exactly one cycle
module multilevel_feedback_queue_scheduler import mfq_pkg::*; #(
    parameter int MAX_LEVELS  = MFQ_MAX_LEVELS,
    parameter int MAX_TASKS   = MFQ_MAX_TASKS,
    parameter int LEVEL_DEPTH = MFQ_LEVEL_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_op,
    input  logic [TASK_W-1:0]        i_task_id,
    input  logic signed [PRIO_W-1:0] i_priority_req,
    output logic                     o_done,
    output logic [STATUS_W-1:0]      o_status,
    output logic [TASK_W-1:0]        o_out_task,
    output logic [OUT_LVL_W-1:0]     o_out_level,
    output logic [SLICE_W-1:0]       o_slice_ms,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int TIW = $clog2(MAX_TASKS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                r_state;
    logic                n_state;
    logic [LC_W-1:0]     r_lc;
    logic [BQ_W-1:0]     r_bq;
    logic [OP_W-1:0]     r_op;
    logic [TASK_W-1:0]   r_task;
    logic [TIW-1:0]      r_tidx;
    logic [LW-1:0]       r_plvl;
    logic [LW-1:0]       r_pick_lvl;
    logic                r_pick_found;

    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [TASK_W-1:0]   r_out_task;
    logic [OUT_LVL_W-1:0] r_out_level;
    logic [SLICE_W-1:0]  r_slice;

    logic [STATUS_W-1:0] n_status;
    logic [TASK_W-1:0]   n_out_task;
    logic [OUT_LVL_W-1:0] n_out_level;
    logic [SLICE_W-1:0]  n_slice;

    logic                    accept;
    logic                    clearing;
    logic [NLV_W-1:0]        levels_used;
    logic [MAX_LEVELS-1:0]   nonempty;
    logic [MAX_LEVELS-1:0]   full;
    logic [MAX_LEVELS-1:0]   avail;
    logic [LW-1:0]           pick_lvl;
    logic                    pick_found;
    logic [TASK_W-1:0]       fifo_data;
    logic [LW:0]             map_q;
    logic [NLV_W-1:0]        base_lvl;
    logic [NLV_W-1:0]        tgt_lvl;
    logic [LW-1:0]           push_lvl;
    t_fifo_cmd               fifo_cmd;
    t_map_wr                 map_wr;

    function automatic logic [TIW-1:0] task_index(input logic [TASK_W-1:0] t);
        logic [16:0] rem;
        rem = 17'(t);
        for (int k = 5; k >= 0; k--) begin
            if (rem >= 17'(MAX_TASKS << k)) begin
                rem = rem - 17'(MAX_TASKS << k);
            end
        end
        return rem[TIW-1:0];
    endfunction

    assign busy        = (r_state != S_IDLE) || clearing;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_lc == '0) begin
            levels_used = NLV_W'(1);
        end else if (NLV_W'(r_lc) > NLV_W'(MAX_LEVELS)) begin
            levels_used = NLV_W'(MAX_LEVELS);
        end else begin
            levels_used = NLV_W'(r_lc);
        end
    end

    // lowest non-empty level in use
    always_comb begin
        pick_lvl   = '0;
        pick_found = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            avail[i] = nonempty[i] && (NLV_W'(i) < levels_used);
        end
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                pick_lvl   = LW'(i);
                pick_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= LC_RESET;
            r_bq <= BQ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LEVEL_COUNT:  r_lc <= i_cfg_data[LC_W-1:0];
                CFG_BASE_QUANTUM: r_bq <= i_cfg_data[BQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_op;
            r_task       <= i_task_id;
            r_tidx       <= task_index(i_task_id);
            r_plvl       <= LW'(prio_level(i_priority_req, levels_used));
            r_pick_lvl   <= pick_lvl;
            r_pick_found <= pick_found;
        end
        if (r_state == S_EXEC) begin
            r_status    <= n_status;
            r_out_task  <= n_out_task;
            r_out_level <= n_out_level;
            r_slice     <= n_slice;
        end
    end

    // target level of a re-enqueue
    always_comb begin
        base_lvl = map_q[LW] ? NLV_W'(map_q[LW-1:0]) : NLV_W'(r_plvl);
        if (r_op == OP_ARRIVAL) begin
            base_lvl = NLV_W'(r_plvl);
        end
        tgt_lvl = base_lvl;
        if (r_op == OP_IO_DONE && base_lvl != '0) begin
            tgt_lvl = base_lvl - 1'b1;
        end else if (r_op == OP_EXPIRE && levels_used > NLV_W'(1)
                     && base_lvl + 1'b1 < levels_used) begin
            tgt_lvl = base_lvl + 1'b1;
        end
        if (tgt_lvl >= levels_used) begin
            tgt_lvl = levels_used - 1'b1;
        end
        push_lvl = tgt_lvl[LW-1:0];
    end

    always_comb begin
        fifo_cmd    = '0;
        map_wr      = '0;
        n_status    = ST_OK;
        n_out_task  = r_task;
        n_out_level = '0;
        n_slice     = '0;
        if (r_state == S_EXEC) begin
            unique case (r_op)
                OP_ARRIVAL, OP_IO_DONE, OP_EXPIRE: begin
                    n_out_level = OUT_LVL_W'(push_lvl);
                    if (full[push_lvl]) begin
                        n_status = ST_FULL;
                    end else begin
                        fifo_cmd.push  = 1'b1;
                        fifo_cmd.level = LVL_MAX_W'(push_lvl);
                        fifo_cmd.data  = r_task;
                        map_wr.we      = 1'b1;
                        map_wr.valid   = 1'b1;
                        map_wr.level   = LVL_MAX_W'(push_lvl);
                        map_wr.addr    = TIDX_MAX_W'(r_tidx);
                    end
                end
                OP_COMPLETE: begin
                    map_wr.we   = 1'b1;
                    map_wr.addr = TIDX_MAX_W'(r_tidx);
                end
                OP_PICK: begin
                    if (r_pick_found) begin
                        fifo_cmd.pop   = 1'b1;
                        fifo_cmd.level = LVL_MAX_W'(r_pick_lvl);
                        map_wr.we      = 1'b1;
                        map_wr.valid   = 1'b1;
                        map_wr.level   = LVL_MAX_W'(r_pick_lvl);
                        map_wr.addr    = TIDX_MAX_W'(task_index(fifo_data));
                        n_out_task     = fifo_data;
                        n_out_level    = OUT_LVL_W'(r_pick_lvl);
                        n_slice        = SLICE_W'(r_bq) << r_pick_lvl;
                    end else begin
                        n_status   = ST_EMPTY;
                        n_out_task = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    mfq_level_store #(
        .MAX_LEVELS  (MAX_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_level_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept && i_op == OP_PICK && pick_found),
        .i_rd_level (pick_lvl),
        .i_cmd      (fifo_cmd),
        .o_rd_data  (fifo_data),
        .o_nonempty (nonempty),
        .o_full     (full)
    );

    mfq_task_map #(
        .MAX_TASKS  (MAX_TASKS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_task_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (task_index(i_task_id)),
        .i_wr       (map_wr),
        .o_rd_data  (map_q),
        .o_clearing (clearing)
    );

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_task  = r_out_task;
    assign o_out_level = r_out_level;
    assign o_slice_ms  = r_slice;

endmodule

FILE: rtl/core/mfq_checker.sv
// mfq_checker: port-level checks on command and result timing and on empty-pick results of the scheduler
// depends on mfq_pkg; bound to multilevel_feedback_queue_scheduler below
module mfq_checker import mfq_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic [STATUS_W-1:0]      o_status,
    input logic [TASK_W-1:0]        o_out_task,
    input logic [OUT_LVL_W-1:0]     o_out_level,
    input logic [SLICE_W-1:0]       o_slice_ms
);

    // every command transfer is followed by its result strobe on o_done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("no result two cycles after command transfer");

    // no result without an earlier command transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without a command");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results on consecutive cycles");

    // an empty pick reports nothing else
    a_empty_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |->
            (o_out_task == '0 && o_out_level == '0 && o_slice_ms == '0))
        else $error("empty pick with non-zero payload");

endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);
